FILE: hdl/bfpc_pkg.sv
package bfpc_pkg;

    // Defaults for the top-level parameters.
    localparam int MAX_FRAME_POINTS_DEF = 65536;
    localparam int COORD_BITS_DEF       = 16;

    // Fixed field widths.
    localparam int BOX_W   = 16;
    localparam int CNT_W   = 17;
    localparam int CENT_W  = 16;
    localparam int STRD_W  = 8;
    localparam int CIDX_W  = 3;
    localparam int CDATA_W = 17;

    // The hit counter saturates at this value at the latest.
    localparam int COUNT_LIMIT = 131071;

    // Register reset values.
    localparam logic signed [BOX_W-1:0] BOX_MIN_X_RST      = 16'sd300;
    localparam logic signed [BOX_W-1:0] SEARCH_LIMIT_X_RST = 16'sd700;
    localparam logic signed [BOX_W-1:0] BOX_MIN_Y_RST      = -16'sd300;
    localparam logic signed [BOX_W-1:0] BOX_MAX_Y_RST      = 16'sd300;
    localparam logic signed [BOX_W-1:0] BOX_MIN_Z_RST      = 16'sd100;
    localparam logic signed [BOX_W-1:0] BOX_MAX_Z_RST      = 16'sd1500;
    localparam logic [CNT_W-1:0]        HIT_THRESHOLD_RST  = 17'd100;
    localparam logic [STRD_W-1:0]       KEEP_STRIDE_RST    = 8'd9;

    typedef enum logic [CIDX_W-1:0] {
        REG_BOX_MIN_X      = 3'd0,
        REG_SEARCH_LIMIT_X = 3'd1,
        REG_BOX_MIN_Y      = 3'd2,
        REG_BOX_MAX_Y      = 3'd3,
        REG_BOX_MIN_Z      = 3'd4,
        REG_BOX_MAX_Z      = 3'd5,
        REG_HIT_THRESHOLD  = 3'd6,
        REG_KEEP_STRIDE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic signed [BOX_W-1:0] box_min_x;
        logic signed [BOX_W-1:0] search_limit_x;
        logic signed [BOX_W-1:0] box_min_y;
        logic signed [BOX_W-1:0] box_max_y;
        logic signed [BOX_W-1:0] box_min_z;
        logic signed [BOX_W-1:0] box_max_z;
        logic [CNT_W-1:0]        hit_threshold;
        logic [STRD_W-1:0]       keep_stride;
    } cfg_t;

    typedef enum logic [1:0] {
        ST_RUN  = 2'd0,
        ST_PREP = 2'd1,
        ST_DIV  = 2'd2,
        ST_LOAD = 2'd3
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic acc_en;    // a point beat is taken
        logic fin_load;  // the taken beat closes the frame
        logic prep;      // set up the dividers
        logic div_step;  // one quotient bit per lane
        logic out_load;  // write the result register
    } dp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic hit;
    } dp_status_t;

endpackage

FILE: hdl/bfpc_cfg.sv
module bfpc_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [bfpc_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [bfpc_pkg::CDATA_W-1:0]   cfg_data,
    output bfpc_pkg::cfg_t                 cfg
);
    import bfpc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_BOX_MIN_X:      cfg_next.box_min_x      = cfg_data[BOX_W-1:0];
                REG_SEARCH_LIMIT_X: cfg_next.search_limit_x = cfg_data[BOX_W-1:0];
                REG_BOX_MIN_Y:      cfg_next.box_min_y      = cfg_data[BOX_W-1:0];
                REG_BOX_MAX_Y:      cfg_next.box_max_y      = cfg_data[BOX_W-1:0];
                REG_BOX_MIN_Z:      cfg_next.box_min_z      = cfg_data[BOX_W-1:0];
                REG_BOX_MAX_Z:      cfg_next.box_max_z      = cfg_data[BOX_W-1:0];
                REG_HIT_THRESHOLD:  cfg_next.hit_threshold  = cfg_data[CNT_W-1:0];
                REG_KEEP_STRIDE:    cfg_next.keep_stride    = cfg_data[STRD_W-1:0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.box_min_x      <= BOX_MIN_X_RST;
            cfg_reg.search_limit_x <= SEARCH_LIMIT_X_RST;
            cfg_reg.box_min_y      <= BOX_MIN_Y_RST;
            cfg_reg.box_max_y      <= BOX_MAX_Y_RST;
            cfg_reg.box_min_z      <= BOX_MIN_Z_RST;
            cfg_reg.box_max_z      <= BOX_MAX_Z_RST;
            cfg_reg.hit_threshold  <= HIT_THRESHOLD_RST;
            cfg_reg.keep_stride    <= KEEP_STRIDE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hdl/bfpc_ctrl.sv
module bfpc_ctrl #(
    parameter int COORD_BITS = bfpc_pkg::COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  logic                   frame_end,
    input  logic                   out_ready,
    output logic                   in_ready,
    output logic                   out_valid,
    input  bfpc_pkg::dp_status_t   status,
    output bfpc_pkg::dp_cmd_t      cmd
);
    import bfpc_pkg::*;

    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int ITER_W = $clog2(SUM_W);

    state_t              state_reg;
    state_t              state_next;
    logic [ITER_W-1:0]   iter_reg;
    logic [ITER_W-1:0]   iter_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (in_valid && frame_end)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                state_next = status.hit ? ST_DIV : ST_LOAD;
            end
            ST_DIV:
            begin
                if (iter_reg == '0)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    state_next = ST_RUN;
                end
            end
        endcase
    end

    always_comb
    begin
        in_ready     = 1'b0;
        cmd          = '0;
        unique case (state_reg)
            ST_RUN:
            begin
                in_ready     = 1'b1;
                cmd.acc_en   = in_valid;
                cmd.fin_load = in_valid && frame_end;
            end
            ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
            end
            ST_LOAD:
            begin
                cmd.out_load = slot_free;
            end
        endcase
    end

    // One quotient bit per cycle, most significant first.
    always_comb
    begin
        iter_next = iter_reg;
        if (cmd.prep)
        begin
            iter_next = ITER_W'(SUM_W - 1);
        end
        else if (cmd.div_step)
        begin
            iter_next = iter_reg - 1'b1;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

FILE: hdl/bfpc_dp.sv
module bfpc_dp #(
    parameter int MAX_FRAME_POINTS = bfpc_pkg::MAX_FRAME_POINTS_DEF,
    parameter int COORD_BITS       = bfpc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bfpc_pkg::cfg_t                      cfg,
    input  bfpc_pkg::dp_cmd_t                   cmd,
    output bfpc_pkg::dp_status_t                status,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    output logic                                collision,
    output logic signed [bfpc_pkg::CENT_W-1:0]  centroid_x,
    output logic signed [bfpc_pkg::CENT_W-1:0]  centroid_y,
    output logic [bfpc_pkg::CNT_W-1:0]          hit_count
);
    import bfpc_pkg::*;

    localparam int CMP_W = (COORD_BITS > BOX_W) ? COORD_BITS : BOX_W;
    localparam int SUM_W = COORD_BITS + CNT_W;
    localparam int HIT_CAP = (MAX_FRAME_POINTS < COUNT_LIMIT) ? MAX_FRAME_POINTS : COUNT_LIMIT;

    // Frame accumulators.
    logic [STRD_W-1:0]        phase_reg;
    logic [STRD_W-1:0]        phase_next;
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic signed [SUM_W-1:0]  sum_x_reg;
    logic signed [SUM_W-1:0]  sum_x_next;
    logic signed [SUM_W-1:0]  sum_y_reg;
    logic signed [SUM_W-1:0]  sum_y_next;

    // End-of-frame snapshot and divider lanes.
    logic [CNT_W-1:0]         fin_count_reg;
    logic [SUM_W-1:0]         quo_x_reg;
    logic [SUM_W-1:0]         quo_x_next;
    logic [SUM_W-1:0]         quo_y_reg;
    logic [SUM_W-1:0]         quo_y_next;
    logic [CNT_W-1:0]         rem_x_reg;
    logic [CNT_W-1:0]         rem_x_next;
    logic [CNT_W-1:0]         rem_y_reg;
    logic [CNT_W-1:0]         rem_y_next;
    logic                     neg_x_reg;
    logic                     neg_y_reg;

    // Result register.
    logic                     collision_reg;
    logic signed [CENT_W-1:0] centroid_x_reg;
    logic signed [CENT_W-1:0] centroid_y_reg;
    logic [CNT_W-1:0]         hit_count_reg;

    logic [STRD_W-1:0]        stride;
    logic [STRD_W-1:0]        phase_eff;
    logic [STRD_W:0]          phase_inc;
    logic signed [CMP_W-1:0]  px;
    logic signed [CMP_W-1:0]  py;
    logic signed [CMP_W-1:0]  pz;
    logic                     in_box;
    logic                     take;
    logic [CNT_W:0]           trial_x;
    logic [CNT_W:0]           trial_y;
    logic [CENT_W-1:0]        qx_low;
    logic [CENT_W-1:0]        qy_low;

    // A stride of zero behaves as one; a phase left over from a larger stride wraps.
    assign stride    = (cfg.keep_stride == '0) ? STRD_W'(1) : cfg.keep_stride;
    assign phase_eff = (phase_reg >= stride) ? '0 : phase_reg;
    assign phase_inc = {1'b0, phase_eff} + 1'b1;
    assign phase_next = (phase_inc >= {1'b0, stride}) ? '0 : phase_inc[STRD_W-1:0];

    assign px = CMP_W'(point_x);
    assign py = CMP_W'(point_y);
    assign pz = CMP_W'(point_z);

    assign in_box = (px > CMP_W'($signed(cfg.box_min_x)))
                 && (px < CMP_W'($signed(cfg.search_limit_x)))
                 && (py > CMP_W'($signed(cfg.box_min_y)))
                 && (py < CMP_W'($signed(cfg.box_max_y)))
                 && (pz > CMP_W'($signed(cfg.box_min_z)))
                 && (pz < CMP_W'($signed(cfg.box_max_z)));

    assign take = (phase_eff == '0) && in_box && (count_reg < CNT_W'(HIT_CAP));

    assign count_next = take ? count_reg + 1'b1 : count_reg;
    assign sum_x_next = take ? sum_x_reg + SUM_W'(point_x) : sum_x_reg;
    assign sum_y_next = take ? sum_y_reg + SUM_W'(point_y) : sum_y_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.fin_load)
        begin
            phase_reg <= '0;
            count_reg <= '0;
            sum_x_reg <= '0;
            sum_y_reg <= '0;
        end
        else if (cmd.acc_en)
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
        end
    end

    assign status.hit = fin_count_reg > cfg.hit_threshold;

    // Restoring division on magnitudes; the quotient shifts in where the
    // dividend shifts out.
    assign trial_x = {rem_x_reg, quo_x_reg[SUM_W-1]} - {1'b0, fin_count_reg};
    assign trial_y = {rem_y_reg, quo_y_reg[SUM_W-1]} - {1'b0, fin_count_reg};

    always_comb
    begin
        quo_x_next = quo_x_reg;
        quo_y_next = quo_y_reg;
        rem_x_next = rem_x_reg;
        rem_y_next = rem_y_reg;
        if (cmd.fin_load)
        begin
            quo_x_next = sum_x_next;
            quo_y_next = sum_y_next;
        end
        else if (cmd.prep)
        begin
            quo_x_next = quo_x_reg[SUM_W-1] ? -quo_x_reg : quo_x_reg;
            quo_y_next = quo_y_reg[SUM_W-1] ? -quo_y_reg : quo_y_reg;
            rem_x_next = '0;
            rem_y_next = '0;
        end
        else if (cmd.div_step)
        begin
            quo_x_next = {quo_x_reg[SUM_W-2:0], !trial_x[CNT_W]};
            quo_y_next = {quo_y_reg[SUM_W-2:0], !trial_y[CNT_W]};
            rem_x_next = trial_x[CNT_W] ? {rem_x_reg[CNT_W-2:0], quo_x_reg[SUM_W-1]}
                                        : trial_x[CNT_W-1:0];
            rem_y_next = trial_y[CNT_W] ? {rem_y_reg[CNT_W-2:0], quo_y_reg[SUM_W-1]}
                                        : trial_y[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        quo_x_reg <= quo_x_next;
        quo_y_reg <= quo_y_next;
        rem_x_reg <= rem_x_next;
        rem_y_reg <= rem_y_next;
        if (cmd.fin_load)
        begin
            fin_count_reg <= count_next;
        end
        if (cmd.prep)
        begin
            neg_x_reg <= quo_x_reg[SUM_W-1];
            neg_y_reg <= quo_y_reg[SUM_W-1];
        end
    end

    assign qx_low = quo_x_reg[CENT_W-1:0];
    assign qy_low = quo_y_reg[CENT_W-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            collision_reg <= status.hit;
            hit_count_reg <= fin_count_reg;
            if (status.hit)
            begin
                centroid_x_reg <= neg_x_reg ? -qx_low : qx_low;
                centroid_y_reg <= neg_y_reg ? -qy_low : qy_low;
            end
            else
            begin
                centroid_x_reg <= '0;
                centroid_y_reg <= '0;
            end
        end
    end

    assign collision  = collision_reg;
    assign centroid_x = centroid_x_reg;
    assign centroid_y = centroid_y_reg;
    assign hit_count  = hit_count_reg;

endmodule

FILE: hdl/box_filter_point_cloud_centroid.sv
// Channel | Direction | Handshake           | Beat carries
// in      | input     | in_valid, in_ready   | point_x, point_y, point_z, frame_end
// out     | output    | out_valid, out_ready | collision, centroid_x, centroid_y, hit_count
// cfg     | input     | cfg_wr_en            | cfg_index, cfg_data
//
// A point takes one cycle; in_ready stays high while points stream.
// After a frame-closing point, input stalls while the controller runs PREP, then DIV for the
// bit-serial dividers when the frame has a collision, then LOAD until the output slot is free.
// A result waiting in the output register stalls input only at the next frame end.
// Reset clears the frame accumulators and loads the register defaults; no clearing pass is needed.
module box_filter_point_cloud_centroid #(
    parameter int MAX_FRAME_POINTS = bfpc_pkg::MAX_FRAME_POINTS_DEF,
    parameter int COORD_BITS       = bfpc_pkg::COORD_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [COORD_BITS-1:0]        point_x,
    input  logic signed [COORD_BITS-1:0]        point_y,
    input  logic signed [COORD_BITS-1:0]        point_z,
    input  logic                                frame_end,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                collision,
    output logic signed [bfpc_pkg::CENT_W-1:0]  centroid_x,
    output logic signed [bfpc_pkg::CENT_W-1:0]  centroid_y,
    output logic [bfpc_pkg::CNT_W-1:0]          hit_count,
    input  logic                                cfg_wr_en,
    input  logic [bfpc_pkg::CIDX_W-1:0]         cfg_index,
    input  logic [bfpc_pkg::CDATA_W-1:0]        cfg_data
);
    import bfpc_pkg::*;

    cfg_t       cfg;
    dp_cmd_t    cmd;
    dp_status_t status;

    bfpc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bfpc_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .frame_end (frame_end),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .status    (status),
        .cmd       (cmd)
    );

    bfpc_dp #(
        .MAX_FRAME_POINTS (MAX_FRAME_POINTS),
        .COORD_BITS       (COORD_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .point_x    (point_x),
        .point_y    (point_y),
        .point_z    (point_z),
        .collision  (collision),
        .centroid_x (centroid_x),
        .centroid_y (centroid_y),
        .hit_count  (hit_count)
    );

endmodule

FILE: hdl/bfpc_checker.sv
module bfpc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_ready,
    input logic                               frame_end,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic                               collision,
    input logic [bfpc_pkg::CENT_W-1:0]        centroid_x,
    input logic [bfpc_pkg::CENT_W-1:0]        centroid_y,
    input logic [bfpc_pkg::CNT_W-1:0]         hit_count
);

    // A held result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(collision)
            && $stable(centroid_x) && $stable(centroid_y) && $stable(hit_count))
    else $error("result beat changed while stalled");

    assert property (@(posedge clk) !rst_n |-> !out_valid)
    else $error("result valid during reset");

    // Without a collision the centroid reads as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !collision |-> centroid_x == '0 && centroid_y == '0)
    else $error("centroid nonzero without collision");

    // A collision needs at least one counted point.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collision |-> hit_count != '0)
    else $error("collision with an empty count");

    // Closing a frame always stalls input in the following cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && frame_end |=> !in_ready)
    else $error("input taken right after a frame end");

endmodule

bind box_filter_point_cloud_centroid bfpc_checker u_bfpc_checker (.*);
